### hw/rtl/psa_pkg.sv
// Shared constants and types for the page span allocator.
`default_nettype none
package psa_pkg;
    localparam int MAX_SPAN_PAGES = 128;
    localparam int TOTAL_PAGES    = 1024;
    localparam int CHUNK_PAGES    = MAX_SPAN_PAGES - 1;

    localparam int PAGE_W  = 10;
    localparam int LEN_W   = 7;
    localparam int LIST_W  = 7;
    localparam int FRESH_W = 11;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOP   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_NOMAP = 2'd3;

    // list pointer with a null flag (vld low means null)
    typedef struct packed {
        logic              vld;
        logic [PAGE_W-1:0] ptr;
    } t_link;

    typedef struct packed {
        logic              en;
        logic [LIST_W-1:0] addr;
        t_link             data;
    } t_head_wr;
endpackage
`default_nettype wire

### hw/rtl/psa_head_table.sv
// Free-list head table: one entry per span size, null after reset.
`default_nettype none
module psa_head_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [psa_pkg::LIST_W-1:0] i_rd_addr,
    input  wire psa_pkg::t_head_wr          i_wr,
    output psa_pkg::t_link                  o_rd
);
    localparam int DEPTH = 1 << psa_pkg::LIST_W;

    logic [psa_pkg::PAGE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    psa_pkg::t_link             r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data.ptr;
        end
        r_rd.ptr <= r_mem[i_rd_addr];
    end

    // valid bits live in flops so reset empties every list at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd.vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= i_wr.data.vld;
            end
            r_rd.vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd = r_rd;
endmodule
`default_nettype wire

### hw/rtl/page_span_allocator_core.sv
// Top level of the page span allocator: sequencer around the page and list memories.
// An allocate with no free span of the requested size scans the larger sizes upward and
// splits the first span it finds; one that maps a fresh chunk also runs a second search.
// A release merges with each free predecessor span in turn; at page 0 there is none.
// One item in flight; the next item is taken once the result sits in the output register.
// Reset (synchronous, active low) empties all lists and the page map; no clearing pass.
`default_nettype none
module page_span_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [6:0]  i_page_count,
    input  wire logic [9:0]  i_page_id,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [9:0]       o_span_start,
    output logic [6:0]       o_span_pages
);
    localparam int PW = psa_pkg::PAGE_W;
    localparam int LW = psa_pkg::LEN_W;
    localparam int HW = psa_pkg::LIST_W;
    localparam int FW = psa_pkg::FRESH_W;
    localparam int TP = psa_pkg::TOTAL_PAGES;

    localparam logic [4:0] S_IDLE = 5'd0,  S_A0  = 5'd1,  S_A1  = 5'd2,  S_POP = 5'd3,
                           S_SCAN = 5'd4,  S_SP0 = 5'd5,  S_SP1 = 5'd6,  S_SP2 = 5'd7,
                           S_SP3  = 5'd8,  S_MAP = 5'd9,  S_RF0 = 5'd10, S_RF1 = 5'd11,
                           S_RF2  = 5'd12, S_R0  = 5'd13, S_R1  = 5'd14, S_M0  = 5'd15,
                           S_M1   = 5'd16, S_M2  = 5'd17, S_M3  = 5'd18, S_M4  = 5'd19,
                           S_FIN  = 5'd20, S_PS1 = 5'd21, S_PS2 = 5'd22, S_L0  = 5'd23,
                           S_L1   = 5'd24, S_L2  = 5'd25, S_DONE = 5'd26;

    localparam psa_pkg::t_link NIL = '{vld: 1'b0, ptr: '0};

    // ---- memories ----
    logic [PW-1:0]  r_owner_mem [TP];
    logic           r_free_mem  [TP];
    logic [LW-1:0]  r_len_mem   [TP];
    psa_pkg::t_link r_next_mem  [TP];
    psa_pkg::t_link r_prev_mem  [TP];

    logic           ow_we, fr_we, fr_wd, ln_we, nx_we, pv_we;
    logic [PW-1:0]  ow_wa, ow_wd, fr_wa, ln_wa, nx_wa, pv_wa;
    logic [PW-1:0]  ow_ra, fr_ra, ln_ra, nx_ra, pv_ra;
    logic [LW-1:0]  ln_wd;
    psa_pkg::t_link nx_wd, pv_wd;

    logic [PW-1:0]  r_ow_rd;
    logic           r_fr_rd;
    logic [LW-1:0]  r_ln_rd;
    psa_pkg::t_link r_nx_rd, r_pv_rd;

    always_ff @(posedge i_clk) begin
        if (ow_we) r_owner_mem[ow_wa] <= ow_wd;
        if (fr_we) r_free_mem[fr_wa]  <= fr_wd;
        if (ln_we) r_len_mem[ln_wa]   <= ln_wd;
        if (nx_we) r_next_mem[nx_wa]  <= nx_wd;
        if (pv_we) r_prev_mem[pv_wa]  <= pv_wd;
        r_ow_rd <= r_owner_mem[ow_ra];
        r_fr_rd <= r_free_mem[fr_ra];
        r_ln_rd <= r_len_mem[ln_ra];
        r_nx_rd <= r_next_mem[nx_ra];
        r_pv_rd <= r_prev_mem[pv_ra];
    end

    logic [HW-1:0]     hd_ra;
    psa_pkg::t_head_wr hd_wr;
    psa_pkg::t_link    hd_rd;

    psa_head_table u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (hd_ra),
        .i_wr      (hd_wr),
        .o_rd      (hd_rd)
    );

    // ---- sequencer registers ----
    logic [4:0]     r_state, n_state, r_mret, n_mret;
    logic [LW-1:0]  r_n, n_n, r_len, n_len, r_lo, n_lo, r_mcnt, n_mcnt;
    logic [PW-1:0]  r_p, n_p, r_s, n_s, r_t, n_t, r_o, n_o, r_mpg, n_mpg, r_mown, n_mown;
    logic [FW-1:0]  r_fresh, n_fresh;
    logic [HW:0]    r_i, n_i;
    logic [HW-1:0]  r_chk, n_chk;
    logic           r_pend, n_pend, r_retry, n_retry;
    psa_pkg::t_link r_h, n_h;
    logic [1:0]     r_res_st, n_res_st;
    logic [PW-1:0]  r_res_start, n_res_start;
    logic [LW-1:0]  r_res_pages, n_res_pages;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_ost, n_ost;
    logic [PW-1:0]  r_ostart, n_ostart;
    logic [LW-1:0]  r_opages, n_opages;

    logic [LW:0]    merge_sum;
    logic [LW-1:0]  split_rest;
    logic [FW:0]    fresh_end;

    assign merge_sum  = {1'b0, r_ln_rd} + {1'b0, r_len};
    assign split_rest = r_len - r_n;
    assign fresh_end  = {1'b0, r_fresh} + (FW+1)'(psa_pkg::CHUNK_PAGES);

    always_comb begin
        n_state = r_state;  n_mret = r_mret;  n_n = r_n;
        n_len = r_len;  n_lo = r_lo;  n_mcnt = r_mcnt;  n_p = r_p;  n_s = r_s;
        n_t = r_t;  n_o = r_o;  n_mpg = r_mpg;  n_mown = r_mown;  n_fresh = r_fresh;
        n_i = r_i;  n_chk = r_chk;  n_pend = r_pend;  n_retry = r_retry;  n_h = r_h;
        n_res_st = r_res_st;  n_res_start = r_res_start;  n_res_pages = r_res_pages;
        n_ovalid = r_ovalid;  n_ost = r_ost;  n_ostart = r_ostart;  n_opages = r_opages;

        ow_we = 1'b0;  ow_wa = '0;  ow_wd = '0;  ow_ra = '0;
        fr_we = 1'b0;  fr_wa = '0;  fr_wd = 1'b0; fr_ra = '0;
        ln_we = 1'b0;  ln_wa = '0;  ln_wd = '0;  ln_ra = '0;
        nx_we = 1'b0;  nx_wa = '0;  nx_wd = NIL; nx_ra = '0;
        pv_we = 1'b0;  pv_wa = '0;  pv_wd = NIL; pv_ra = '0;
        hd_ra = '0;
        hd_wr = '{en: 1'b0, addr: '0, data: NIL};

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n     = i_page_count;
                    n_p     = i_page_id;
                    n_retry = 1'b0;
                    n_res_st = psa_pkg::ST_BAD;  n_res_start = '0;  n_res_pages = '0;
                    n_state = S_DONE;
                    case (i_cmd)
                        psa_pkg::CMD_ALLOC: begin
                            if (i_page_count != '0) n_state = S_A0;
                        end
                        psa_pkg::CMD_RELEASE, psa_pkg::CMD_LOOKUP: begin
                            // a page is mapped exactly when it lies below the bump pointer
                            if ({1'b0, i_page_id} < r_fresh) begin
                                n_state = (i_cmd == psa_pkg::CMD_RELEASE) ? S_R0 : S_L0;
                            end else begin
                                n_res_st = psa_pkg::ST_NOMAP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_A0: begin
                hd_ra   = r_n;
                n_state = S_A1;
            end
            S_A1: begin
                if (hd_rd.vld) begin
                    n_s     = hd_rd.ptr;
                    nx_ra   = hd_rd.ptr;
                    n_state = S_POP;
                end else begin
                    n_i     = r_retry ? (HW+1)'(psa_pkg::CHUNK_PAGES) : ({1'b0, r_n} + 1'b1);
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_POP: begin
                hd_wr = '{en: 1'b1, addr: r_n, data: r_nx_rd};
                if (r_nx_rd.vld) begin
                    pv_we = 1'b1;  pv_wa = r_nx_rd.ptr;  pv_wd = NIL;
                end
                fr_we = 1'b1;  fr_wa = r_s;  fr_wd = 1'b0;
                n_res_st = psa_pkg::ST_OK;  n_res_start = r_s;  n_res_pages = r_n;
                n_state = S_DONE;
            end
            S_SCAN: begin
                // one head read issued per cycle, checked the cycle after
                if (r_pend && hd_rd.vld) begin
                    n_s     = hd_rd.ptr;
                    n_len   = r_chk;
                    n_state = S_SP0;
                end else if (r_i == (HW+1)'(psa_pkg::MAX_SPAN_PAGES)) begin
                    if (r_retry) begin
                        n_res_st = psa_pkg::ST_OOP;  n_res_start = '0;  n_res_pages = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_RF0;
                    end
                end else begin
                    hd_ra  = r_i[HW-1:0];
                    n_chk  = r_i[HW-1:0];
                    n_pend = 1'b1;
                    n_i    = r_i + 1'b1;
                end
            end
            S_SP0: begin
                n_t     = r_s + PW'(r_len) - PW'(r_n);
                nx_ra   = r_s;
                hd_ra   = split_rest;
                n_state = S_SP1;
            end
            S_SP1: begin
                n_h   = hd_rd;
                hd_wr = '{en: 1'b1, addr: r_len, data: r_nx_rd};
                if (r_nx_rd.vld) begin
                    pv_we = 1'b1;  pv_wa = r_nx_rd.ptr;  pv_wd = NIL;
                end
                ln_we = 1'b1;  ln_wa = r_t;  ln_wd = r_n;
                fr_we = 1'b1;  fr_wa = r_t;  fr_wd = 1'b0;
                nx_we = 1'b1;  nx_wa = r_s;  nx_wd = hd_rd;
                n_state = S_SP2;
            end
            S_SP2: begin
                hd_wr = '{en: 1'b1, addr: split_rest, data: '{vld: 1'b1, ptr: r_s}};
                pv_we = 1'b1;  pv_wa = r_s;  pv_wd = NIL;
                ln_we = 1'b1;  ln_wa = r_s;  ln_wd = split_rest;
                n_state = S_SP3;
            end
            S_SP3: begin
                if (r_h.vld) begin
                    pv_we = 1'b1;  pv_wa = r_h.ptr;  pv_wd = '{vld: 1'b1, ptr: r_s};
                end
                n_mpg = r_t;  n_mcnt = r_n;  n_mown = r_t;  n_mret = S_DONE;
                n_res_st = psa_pkg::ST_OK;  n_res_start = r_t;  n_res_pages = r_n;
                n_state = S_MAP;
            end
            S_MAP: begin
                ow_we = 1'b1;  ow_wa = r_mpg;  ow_wd = r_mown;
                if (r_mpg != r_mown) begin
                    fr_we = 1'b1;  fr_wa = r_mpg;  fr_wd = 1'b0;
                end
                n_mpg  = r_mpg + 1'b1;
                n_mcnt = r_mcnt - 1'b1;
                if (r_mcnt == LW'(1)) n_state = r_mret;
            end
            S_RF0: begin
                if (fresh_end <= (FW+1)'(TP)) begin
                    hd_ra   = HW'(psa_pkg::CHUNK_PAGES);
                    n_state = S_RF1;
                end else begin
                    n_res_st = psa_pkg::ST_OOP;  n_res_start = '0;  n_res_pages = '0;
                    n_state  = S_DONE;
                end
            end
            S_RF1: begin
                n_h   = hd_rd;
                nx_we = 1'b1;  nx_wa = r_fresh[PW-1:0];  nx_wd = hd_rd;
                pv_we = 1'b1;  pv_wa = r_fresh[PW-1:0];  pv_wd = NIL;
                ln_we = 1'b1;  ln_wa = r_fresh[PW-1:0];  ln_wd = LW'(psa_pkg::CHUNK_PAGES);
                fr_we = 1'b1;  fr_wa = r_fresh[PW-1:0];  fr_wd = 1'b1;
                hd_wr = '{en: 1'b1, addr: HW'(psa_pkg::CHUNK_PAGES),
                          data: '{vld: 1'b1, ptr: r_fresh[PW-1:0]}};
                n_state = S_RF2;
            end
            S_RF2: begin
                if (r_h.vld) begin
                    pv_we = 1'b1;  pv_wa = r_h.ptr;
                    pv_wd = '{vld: 1'b1, ptr: r_fresh[PW-1:0]};
                end
                n_mpg   = r_fresh[PW-1:0];
                n_mown  = r_fresh[PW-1:0];
                n_mcnt  = LW'(psa_pkg::CHUNK_PAGES);
                n_mret  = S_A0;
                n_fresh = fresh_end[FW-1:0];
                n_retry = 1'b1;
                n_state = S_MAP;
            end
            S_R0: begin
                ow_ra = r_p;  fr_ra = r_p;  ln_ra = r_p;
                n_state = S_R1;
            end
            S_R1: begin
                if (r_ow_rd != r_p || r_fr_rd) begin
                    n_res_st = psa_pkg::ST_BAD;  n_res_start = '0;  n_res_pages = '0;
                    n_state  = S_DONE;
                end else begin
                    n_s     = r_p;
                    n_len   = r_ln_rd;
                    n_state = S_M0;
                end
            end
            S_M0: begin
                if (r_s == '0) begin
                    n_state = S_FIN;
                end else begin
                    ow_ra   = r_s - 1'b1;
                    n_state = S_M1;
                end
            end
            S_M1: begin
                n_o   = r_ow_rd;
                fr_ra = r_ow_rd;
                ln_ra = r_ow_rd;
                n_state = S_M2;
            end
            S_M2: begin
                if (!r_fr_rd || merge_sum > (LW+1)'(psa_pkg::CHUNK_PAGES)) begin
                    n_state = S_FIN;
                end else begin
                    n_lo  = r_ln_rd;
                    nx_ra = r_o;
                    pv_ra = r_o;
                    n_state = S_M3;
                end
            end
            S_M3: begin
                // unlink the free predecessor from its list
                if (r_pv_rd.vld) begin
                    nx_we = 1'b1;  nx_wa = r_pv_rd.ptr;  nx_wd = r_nx_rd;
                end else begin
                    hd_wr = '{en: 1'b1, addr: r_lo, data: r_nx_rd};
                end
                if (r_nx_rd.vld) begin
                    pv_we = 1'b1;  pv_wa = r_nx_rd.ptr;  pv_wd = r_pv_rd;
                end
                n_mpg = r_s;  n_mcnt = r_len;  n_mown = r_o;  n_mret = S_M4;
                n_state = S_MAP;
            end
            S_M4: begin
                n_len = r_len + r_lo;
                n_s   = r_o;
                ln_we = 1'b1;  ln_wa = r_o;  ln_wd = r_len + r_lo;
                n_state = S_M0;
            end
            S_FIN: begin
                ln_we = 1'b1;  ln_wa = r_s;  ln_wd = r_len;
                fr_we = 1'b1;  fr_wa = r_s;  fr_wd = 1'b1;
                hd_ra = r_len;
                n_state = S_PS1;
            end
            S_PS1: begin
                n_h   = hd_rd;
                nx_we = 1'b1;  nx_wa = r_s;  nx_wd = hd_rd;
                pv_we = 1'b1;  pv_wa = r_s;  pv_wd = NIL;
                hd_wr = '{en: 1'b1, addr: r_len, data: '{vld: 1'b1, ptr: r_s}};
                n_state = S_PS2;
            end
            S_PS2: begin
                if (r_h.vld) begin
                    pv_we = 1'b1;  pv_wa = r_h.ptr;  pv_wd = '{vld: 1'b1, ptr: r_s};
                end
                n_res_st = psa_pkg::ST_OK;  n_res_start = r_s;  n_res_pages = r_len;
                n_state  = S_DONE;
            end
            S_L0: begin
                ow_ra   = r_p;
                n_state = S_L1;
            end
            S_L1: begin
                n_o     = r_ow_rd;
                ln_ra   = r_ow_rd;
                n_state = S_L2;
            end
            S_L2: begin
                n_res_st = psa_pkg::ST_OK;  n_res_start = r_o;  n_res_pages = r_ln_rd;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_ostart = r_res_start;
                    n_opages = r_res_pages;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fresh  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_retry  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fresh  <= n_fresh;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_retry  <= n_retry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mret <= n_mret;  r_n <= n_n;  r_len <= n_len;  r_lo <= n_lo;
        r_mcnt <= n_mcnt;  r_p <= n_p;  r_s <= n_s;  r_t <= n_t;  r_o <= n_o;
        r_mpg <= n_mpg;  r_mown <= n_mown;  r_i <= n_i;  r_chk <= n_chk;  r_h <= n_h;
        r_res_st <= n_res_st;  r_res_start <= n_res_start;  r_res_pages <= n_res_pages;
        r_ost <= n_ost;  r_ostart <= n_ostart;  r_opages <= n_opages;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_ost;
    assign o_span_start = r_ostart;
    assign o_span_pages = r_opages;

`ifndef SYNTHESIS
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fresh} <= (FW+1)'(TP))
        else $error("bump pointer beyond page space");

    a_fresh_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fresh != $past(r_fresh)) |->
            ({1'b0, r_fresh} == {1'b0, $past(r_fresh)} + (FW+1)'(psa_pkg::CHUNK_PAGES)))
        else $error("bump pointer moved by other than one chunk");

    a_ok_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == psa_pkg::ST_OK) |-> (o_span_pages != '0))
        else $error("ok result with empty span");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != psa_pkg::ST_OK) |->
            (o_span_start == '0 && o_span_pages == '0))
        else $error("failed result carries a span");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !(r_ovalid && i_stall)) |=> (o_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");
`endif
endmodule
`default_nettype wire

### dv/page_span_allocator_core_tb.sv
// Self-checking testbench for the page span allocator core.
`timescale 1ns / 1ps
`default_nettype none
module page_span_allocator_core_tb;
    localparam int NUM_RAND   = 1800;
    localparam int WDOG_LIMIT = 5000;
    localparam int LONG_HOLD  = 600;
    localparam int NIL        = -1;
    localparam int TPAGES     = psa_pkg::TOTAL_PAGES;
    localparam int MAXSP      = psa_pkg::MAX_SPAN_PAGES;
    localparam int CHUNK      = psa_pkg::CHUNK_PAGES;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] page_count;
        logic [9:0] page_id;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] span_start;
        logic [6:0] span_pages;
    } t_rsp;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall_out;
    logic [1:0] in_cmd;
    logic [6:0] in_count;
    logic [9:0] in_page;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] out_status;
    logic [9:0] out_start;
    logic [6:0] out_pages;

    page_span_allocator_core u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall_out),
        .i_cmd        (in_cmd),
        .i_page_count (in_count),
        .i_page_id    (in_page),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_status     (out_status),
        .o_span_start (out_start),
        .o_span_pages (out_pages)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---- allocator shadow state ----
    int  owner_of  [TPAGES];
    bit  mapped    [TPAGES];
    int  span_len  [TPAGES];
    bit  is_free   [TPAGES];
    int  nxt       [TPAGES];
    int  prv       [TPAGES];
    int  head      [MAXSP];
    int  bump_ptr;

    function automatic void free_push(int s);
        int h;
        h = head[span_len[s]];
        nxt[s] = h;
        prv[s] = NIL;
        if (h != NIL) prv[h] = s;
        head[span_len[s]] = s;
    endfunction

    function automatic void free_unlink(int s);
        int p;
        int n;
        p = prv[s];
        n = nxt[s];
        if (p != NIL) nxt[p] = n;
        else head[span_len[s]] = n;
        if (n != NIL) prv[n] = p;
    endfunction

    function automatic void claim_pages(int first, int count, int own);
        for (int i = 0; i < count; i++) begin
            if (first + i < TPAGES) begin
                owner_of[first + i] = own;
                mapped[first + i]   = 1'b1;
            end
        end
    endfunction

    function automatic bit take_span(int n, output int start);
        int s;
        int len;
        int t;
        start = 0;
        if (head[n] != NIL) begin
            s = head[n];
            free_unlink(s);
            is_free[s] = 1'b0;
            start = s;
            return 1'b1;
        end
        for (int i = n + 1; i < MAXSP; i++) begin
            if (head[i] != NIL) begin
                s = head[i];
                free_unlink(s);
                len = span_len[s];
                t = s + len - n;
                span_len[t] = n;
                is_free[t] = 1'b0;
                claim_pages(t, n, t);
                span_len[s] = len - n;
                free_push(s);
                start = t;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_rsp alloc_step(t_req rq);
        t_rsp r;
        int   n;
        int   p;
        int   s;
        int   len;
        int   o;
        bit   ok;
        n = rq.page_count;
        p = rq.page_id;
        r = '0;
        r.status = psa_pkg::ST_BAD;
        if (rq.cmd == psa_pkg::CMD_ALLOC) begin
            if (n >= 1 && n < MAXSP) begin
                ok = take_span(n, s);
                if (!ok && bump_ptr + CHUNK <= TPAGES) begin
                    span_len[bump_ptr] = CHUNK;
                    is_free[bump_ptr]  = 1'b1;
                    claim_pages(bump_ptr, CHUNK, bump_ptr);
                    free_push(bump_ptr);
                    bump_ptr += CHUNK;
                    ok = take_span(n, s);
                end
                if (ok) begin
                    r.status = psa_pkg::ST_OK;
                    r.span_start = s[9:0];
                    r.span_pages = span_len[s][6:0];
                end else begin
                    r.status = psa_pkg::ST_OOP;
                end
            end
        end else if (rq.cmd == psa_pkg::CMD_RELEASE) begin
            if (!mapped[p]) begin
                r.status = psa_pkg::ST_NOMAP;
            end else if (owner_of[p] == p && !is_free[p]) begin
                s = p;
                len = span_len[s];
                // backward merge only, capped at one chunk
                while (s > 0) begin
                    if (!mapped[s - 1]) break;
                    o = owner_of[s - 1];
                    if (!is_free[o]) break;
                    if (span_len[o] + len > CHUNK) break;
                    free_unlink(o);
                    claim_pages(s, len, o);
                    is_free[s] = 1'b0;
                    len += span_len[o];
                    s = o;
                    span_len[s] = len;
                end
                span_len[s] = len;
                is_free[s] = 1'b1;
                free_push(s);
                r.status = psa_pkg::ST_OK;
                r.span_start = s[9:0];
                r.span_pages = len[6:0];
            end
        end else if (rq.cmd == psa_pkg::CMD_LOOKUP) begin
            if (mapped[p]) begin
                r.status = psa_pkg::ST_OK;
                r.span_start = owner_of[p][9:0];
                r.span_pages = span_len[owner_of[p]][6:0];
            end else begin
                r.status = psa_pkg::ST_NOMAP;
            end
        end
        return r;
    endfunction

    // ---- queues and counters ----
    t_req pending_q[$];
    t_rsp expected_q[$];
    int   live_spans[$];
    int   sent_cnt;
    int   rcvd_cnt;
    int   err_cnt;
    int   idle_cnt;
    int   phase;
    bit   gen_done;
    bit   sender_hold;
    bit   in_fire;

    function automatic t_rsp issue(logic [1:0] cmd, logic [6:0] cnt, logic [9:0] pg);
        t_req rq;
        t_rsp r;
        rq = '{cmd: cmd, page_count: cnt, page_id: pg};
        r = alloc_step(rq);
        pending_q.push_back(rq);
        expected_q.push_back(r);
        if (cmd == psa_pkg::CMD_ALLOC && r.status == psa_pkg::ST_OK)
            live_spans.push_back(int'(r.span_start));
        if (cmd == psa_pkg::CMD_RELEASE && r.status == psa_pkg::ST_OK) begin
            for (int i = 0; i < live_spans.size(); i++)
                if (live_spans[i] == pg) begin
                    live_spans.delete(i);
                    break;
                end
        end
        return r;
    endfunction

    // ---- stimulus ----
    initial begin
        t_rsp a;
        t_rsp b;
        int   k;
        int   sel;
        int   idx;
        for (int i = 0; i < TPAGES; i++) begin
            owner_of[i] = 0;
            mapped[i]   = 1'b0;
            span_len[i] = 0;
            is_free[i]  = 1'b0;
        end
        for (int i = 0; i < MAXSP; i++) head[i] = NIL;
        bump_ptr = 0;
        gen_done = 1'b0;

        // directed
        void'(issue(psa_pkg::CMD_LOOKUP, 7'd0, 10'd1023));
        void'(issue(psa_pkg::CMD_RELEASE, 7'd127, 10'd0));
        void'(issue(psa_pkg::CMD_ALLOC, 7'd0, 10'd0));
        void'(issue(CMD_UNKNOWN, 7'h7f, 10'h3ff));
        a = issue(psa_pkg::CMD_ALLOC, 7'd1, 10'd0);
        b = issue(psa_pkg::CMD_ALLOC, 7'd5, 10'd0);
        void'(issue(psa_pkg::CMD_LOOKUP, 7'd0, b.span_start + 10'd2));
        void'(issue(psa_pkg::CMD_RELEASE, 7'd0, b.span_start + 10'd1));
        void'(issue(psa_pkg::CMD_RELEASE, 7'd0, b.span_start));
        void'(issue(psa_pkg::CMD_RELEASE, 7'd0, b.span_start));
        void'(issue(psa_pkg::CMD_ALLOC, 7'd5, 10'd0));
        void'(issue(psa_pkg::CMD_ALLOC, 7'd3, 10'd0));
        void'(issue(psa_pkg::CMD_RELEASE, 7'd0, a.span_start));
        void'(issue(psa_pkg::CMD_ALLOC, 7'd127, 10'd0));
        void'(issue(psa_pkg::CMD_ALLOC, 7'd126, 10'd0));
        void'(issue(psa_pkg::CMD_LOOKUP, 7'd0, 10'd0));
        void'(issue(psa_pkg::CMD_LOOKUP, 7'd0, 10'd512));
        while (live_spans.size() > 0)
            void'(issue(psa_pkg::CMD_RELEASE, 7'd0,
                        live_spans[live_spans.size() - 1][9:0]));
        void'(issue(psa_pkg::CMD_LOOKUP, 7'd0, 10'd127));

        // random
        for (int i = 0; i < NUM_RAND; i++) begin
            sel = $urandom_range(0, 99);
            if (live_spans.size() > 40 && sel < 45) sel += 45;
            if (sel < 45) begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 20);
                void'(issue(psa_pkg::CMD_ALLOC, k[6:0], 10'($urandom)));
            end else if (sel < 78 && live_spans.size() > 0) begin
                idx = $urandom_range(0, live_spans.size() - 1);
                void'(issue(psa_pkg::CMD_RELEASE, 7'($urandom), live_spans[idx][9:0]));
            end else if (sel < 84) begin
                void'(issue(psa_pkg::CMD_RELEASE, 7'($urandom), 10'($urandom)));
            end else if (sel < 97) begin
                void'(issue(psa_pkg::CMD_LOOKUP, 7'($urandom), 10'($urandom)));
            end else begin
                void'(issue(CMD_UNKNOWN, 7'($urandom), 10'($urandom)));
            end
        end
        gen_done = 1'b1;
    end

    // ---- reset ----
    initial begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // handshake sampling at the rising edge
    always @(posedge clk) begin
        in_fire = rst_n && in_valid && !in_stall_out;
    end

    // ---- driver ----
    initial begin
        in_valid = 1'b0;
        in_cmd   = '0;
        in_count = '0;
        in_page  = '0;
        sent_cnt = 0;
        sender_hold = 1'b0;
    end

    always @(negedge clk) begin
        t_req rq;
        bit   idle;
        if (rst_n) begin
            if (in_fire) sent_cnt++;
            phase = sent_cnt * 4 / (NUM_RAND + 60);
            // one full drain midway through the run
            sender_hold = (sent_cnt == NUM_RAND / 2) && (rcvd_cnt != sent_cnt);
            if (!in_valid || in_fire) begin
                idle = (phase == 1 && $urandom_range(0, 99) < 48) ||
                       (phase == 3 && $urandom_range(0, 99) < 8);
                if (pending_q.size() > 0 && !idle && !sender_hold) begin
                    rq = pending_q[0];
                    pending_q.delete(0);
                    in_valid <= 1'b1;
                    in_cmd   <= rq.cmd;
                    in_count <= rq.page_count;
                    in_page  <= rq.page_id;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---- receiver stall ----
    int hold_left;
    bit hold_done;
    initial begin
        out_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
    end

    always @(negedge clk) begin
        if (!hold_done && sent_cnt >= 300) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= (phase == 2 && $urandom_range(0, 99) < 48) ||
                         (phase == 3 && $urandom_range(0, 99) < 8);
        end
    end

    // ---- monitor and checker ----
    initial begin
        rcvd_cnt = 0;
        err_cnt  = 0;
        idle_cnt = 0;
    end

    always @(posedge clk) begin
        t_rsp exp_r;
        t_rsp got;
        if (rst_n) begin
            if (in_valid && !in_stall_out || out_valid && !out_stall) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
            if (out_valid && !out_stall) begin
                rcvd_cnt++;
                got = '{status: out_status, span_start: out_start, span_pages: out_pages};
                if (expected_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected item: %p", got);
                end else begin
                    exp_r = expected_q[0];
                    expected_q.delete(0);
                    if (got !== exp_r) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("item %0d mismatch: exp %p got %p", rcvd_cnt, exp_r, got);
                    end
                end
            end
        end
    end

    // ---- end of run ----
    initial begin
        wait (gen_done && rst_n);
        wait (pending_q.size() == 0 && !in_valid);
        wait (rcvd_cnt == sent_cnt);
        repeat (300) @(posedge clk);
        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### page_span_allocator_core.f
hw/rtl/psa_pkg.sv
hw/rtl/psa_head_table.sv
hw/rtl/page_span_allocator_core.sv
dv/page_span_allocator_core_tb.sv
